// ===== hdl/uirf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uirf_pkg - shared types and constants for the USB interface rule filter
// Rule layout, command codes, controller states and the control/status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package uirf_pkg;

	// Table geometry
	localparam int MAX_RULES = 16;
	localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int COUNT_W   = $clog2(MAX_RULES + 1);

	// Field constants
	localparam logic [7:0] HUB_CLASS   = 8'd9;
	localparam int         CLASS_SHIFT = 8;
	localparam int         OUT_IDX_W   = 4;

	// Enable bits of a rule mask
	localparam int MASK_W       = 6;
	localparam int MB_CLASS     = 0;
	localparam int MB_SUBCLASS  = 1;
	localparam int MB_PROTOCOL  = 2;
	localparam int MB_VENDOR    = 3;
	localparam int MB_PRODUCT   = 4;
	localparam int MB_FOCUS     = 5;

	// Stream payload widths
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_CHECK  = 2'd1,
		CMD_CLEAR  = 2'd2
	} command_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic              allow;
		logic              focus;
		logic [15:0]       pid;
		logic [15:0]       vid;
		logic [7:0]        proto;
		logic [7:0]        subcls;
		logic [7:0]        cls;
		logic [MASK_W-1:0] mask;
	} rule_t;

	// Controller -> datapath
	typedef struct packed {
		logic capture;   // latch the incoming transfer
		logic exec;      // run append/clear, start a scan
		logic scan;      // one rule compare per cycle
		logic finish;    // load the result register
	} dp_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic needs_scan;
		logic hit;
		logic scan_end;
		logic slot_free;
	} dp_sts_t;

	function automatic logic rule_hit(rule_t r, logic [7:0] cls, logic [7:0] sub,
		logic [15:0] vid, logic [15:0] pid);
		rule_hit = (!r.mask[MB_CLASS]    || (r.cls == cls))    &&
		           (!r.mask[MB_SUBCLASS] || (r.subcls == sub)) &&
		           (!r.mask[MB_PROTOCOL] || (r.proto == 8'd0)) &&
		           (!r.mask[MB_VENDOR]   || (r.vid == vid))    &&
		           (!r.mask[MB_PRODUCT]  || (r.pid == pid))    &&
		           (!r.mask[MB_FOCUS]    || r.focus);
	endfunction

endpackage

// ===== hdl/uirf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uirf_ctrl - command sequencer
// Accepts one transfer, runs it through execute and, if needed, rule scan,
// and hands the result to the output register once that register has room.
// ----------------------------------------------------------------------------
module uirf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  uirf_pkg::dp_sts_t sts,
	output uirf_pkg::dp_cmd_t cmd
);
	import uirf_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.needs_scan ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the result register is free
				if (sts.slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/uirf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uirf_dp - rule table and compare datapath
// Holds the rule memory, rule count, running device verdict, the scan
// pipeline (registered read, then compare) and the result register.
// ----------------------------------------------------------------------------
module uirf_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  uirf_pkg::dp_cmd_t                 cmd,
	output uirf_pkg::dp_sts_t                 sts,
	input  logic [1:0]                        in_user,
	input  logic [uirf_pkg::IN_DATA_W-1:0]    in_data,
	input  logic                              in_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [uirf_pkg::OUT_DATA_W-1:0]   out_data,
	output logic                              out_last
);
	import uirf_pkg::*;

	// Latched transfer
	logic [1:0]        cmd_q;
	logic [15:0]       vid_q;
	logic [15:0]       pid_q;
	logic [15:0]       cc_q;
	logic              last_q;
	logic [MASK_W-1:0] mask_q;
	logic [7:0]        proto_q;
	logic              focus_q;
	logic              allow_q;

	// Table state
	rule_t              mem [MAX_RULES];
	logic [COUNT_W-1:0] count_q;
	logic               acc_q;
	logic               full_q;

	// Scan
	logic [COUNT_W-1:0] walk_q;
	logic [COUNT_W-1:0] rd_idx;
	logic               issue;
	rule_t              rd_s1;
	logic [COUNT_W-1:0] rd_idx_s1;
	logic               rd_vld_s1;
	logic               match_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic               match_allow_q;

	// Result
	logic [OUT_DATA_W-1:0]  out_data_q;
	logic                   out_last_q;
	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  res_data;
	logic                   res_last;

	logic [7:0]             cls;
	logic [7:0]             sub;
	logic                   is_hub;
	logic                   table_full;
	logic                   hit;
	rule_t                  new_rule;
	logic [IDX_W+OUT_IDX_W-1:0] idx_wide;
	logic                   r_allowed;
	logic                   r_matched;
	logic                   r_dev;

	assign cls        = cc_q[CLASS_SHIFT +: 8];
	assign sub        = cc_q[7:0];
	assign is_hub     = (cls == HUB_CLASS);
	assign table_full = (count_q >= COUNT_W'(MAX_RULES));

	assign new_rule.allow  = allow_q;
	assign new_rule.focus  = focus_q;
	assign new_rule.pid    = pid_q;
	assign new_rule.vid    = vid_q;
	assign new_rule.proto  = proto_q;
	assign new_rule.subcls = sub;
	assign new_rule.cls    = cls;
	assign new_rule.mask   = mask_q;

	// Capture the transfer
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= in_user;
			vid_q   <= in_data[15:0];
			pid_q   <= in_data[31:16];
			cc_q    <= in_data[47:32];
			mask_q  <= in_data[53:48];
			proto_q <= in_data[61:54];
			focus_q <= in_data[62];
			allow_q <= in_data[63];
			last_q  <= in_last;
		end
	end

	// Rule memory: append writes at the fill point
	always_ff @(posedge clk) begin
		if (cmd.exec && (cmd_q == CMD_APPEND) && !table_full) begin
			mem[count_q[IDX_W-1:0]] <= new_rule;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			full_q  <= 1'b0;
		end else if (cmd.exec) begin
			full_q <= (cmd_q == CMD_APPEND) && table_full;
			if ((cmd_q == CMD_APPEND) && !table_full) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (cmd_q == CMD_CLEAR) begin
				count_q <= '0;
			end
		end
	end

	// Scan: read one rule a cycle, compare it the cycle after
	assign sts.needs_scan = (cmd_q == CMD_CHECK) && !is_hub && (count_q != '0);
	assign issue  = (cmd.exec && sts.needs_scan) || (cmd.scan && (walk_q < count_q));
	assign rd_idx = cmd.exec ? '0 : walk_q;

	always_ff @(posedge clk) begin
		rd_s1     <= mem[rd_idx[IDX_W-1:0]];
		rd_idx_s1 <= rd_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			walk_q    <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				walk_q <= rd_idx + COUNT_W'(1);
			end
		end
	end

	assign hit          = rd_vld_s1 && rule_hit(rd_s1, cls, sub, vid_q, pid_q);
	assign sts.hit      = hit;
	assign sts.scan_end = rd_vld_s1 && (rd_idx_s1 == (count_q - COUNT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (cmd.exec) begin
			match_q <= 1'b0;
		end else if (cmd.scan && hit) begin
			match_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			match_idx_q   <= '0;
			match_allow_q <= 1'b0;
		end else if (cmd.scan && hit) begin
			match_idx_q   <= rd_idx_s1[IDX_W-1:0];
			match_allow_q <= rd_s1.allow;
		end
	end

	// Result assembly
	assign idx_wide  = {{OUT_IDX_W{1'b0}}, match_idx_q};
	assign r_matched = (cmd_q == CMD_CHECK) && !is_hub && match_q;
	assign r_allowed = r_matched && match_allow_q;
	assign r_dev     = acc_q | r_allowed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 1'b0;
		end else if (cmd.finish && (cmd_q == CMD_CHECK)) begin
			acc_q <= last_q ? 1'b0 : r_dev;
		end
	end

	always_comb begin
		res_data = '0;
		res_last = 1'b0;
		case (cmd_q)
			CMD_APPEND: begin
				res_data[0] = full_q;
			end
			CMD_CHECK: begin
				res_data[1]   = r_allowed;
				res_data[2]   = r_matched;
				res_data[6:3] = r_matched ? idx_wide[OUT_IDX_W-1:0] : '0;
				res_data[7]   = is_hub;
				res_data[8]   = r_dev;
				res_last      = last_q;
			end
			default: begin
				res_data = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= res_data;
			out_last_q <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.slot_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;
	assign out_last      = out_last_q;

endmodule

// ===== hdl/usb_interface_rule_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_interface_rule_filter - first-match allow/deny filter for USB interfaces
// Ordered rule table with append, clear and check commands.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one command per transfer; tuser selects it
//   (append rule, check interface, clear table) and tlast marks the last
//   interface of a device on a check. Master stream m_axis returns exactly one
//   result transfer per command; tlast is set on the result of a device's
//   last interface, whose device_allowed bit is then the final verdict.
//   Append, clear, hub checks and checks against an empty table go from
//   capture to execute to the result register. A check walks the table one
//   rule per cycle from the single read port of the rule memory, the read
//   registered ahead of the compare, and stops at the first matching rule
//   or after the last rule when none matches.
//   One command is in flight at a time; s_axis_tready is high only while the
//   sequencer is idle, and a new command is taken while a result still waits.
//   If m_axis stalls, the finished result is held in the sequencer until the
//   output register frees; no result is dropped or repeated.
//   Reset empties the table and clears the running device verdict; rule
//   entries need no clearing since only entries below the count are read.
// ----------------------------------------------------------------------------
module usb_interface_rule_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// vendor_id[15:0], product_id[31:16], class_code[47:32], rule_mask[53:48],
	// rule_protocol[61:54], rule_focus[62], rule_allow[63]
	input  logic [uirf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// command[1:0]
	input  logic [1:0]                      s_axis_tuser,
	// last_interface
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status[0], iface_allowed[1], rule_matched[2], matched_rule[6:3],
	// hub_rejected[7], device_allowed[8], zero[15:9]
	output logic [uirf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// device_done
	output logic                            m_axis_tlast
);
	import uirf_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer: accept, execute, scan, deliver
	uirf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Rule table, comparator and result register
	uirf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_user   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	// Never overwrite a result that the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result register overwritten while stalled");

	// One command in flight: no transfer accepted right after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a command is in progress");

	// A hub interface never reports a rule match or an allow
	a_hub_denied: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[7]) |-> (!m_axis_tdata[1] && !m_axis_tdata[2]))
		else $error("hub interface reported as matched or allowed");

	// The device verdict covers every allowed interface
	a_dev_covers_iface: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[8])
		else $error("allowed interface missing from device verdict");

endmodule
